// ===== rtl/diff_drive_gait_planner_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gait planner
// Shared property forms; clock and reset names follow the top level.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_GAIT_PLANNER_ASSERT_SVH
`define DIFF_DRIVE_GAIT_PLANNER_ASSERT_SVH

// Same-cycle implication.
`define DDGP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gait planner assertion failed");

// Next-cycle implication.
`define DDGP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gait planner assertion failed");

`endif

// ===== rtl/ddgp_pkg.sv =====
// ----------------------------------------------------------------------------
// ddgp_pkg
// Types and constants shared by the gait planner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ddgp_pkg;

   typedef struct packed {
      logic signed [15:0] vx_mm_s;
      logic signed [15:0] vy_mm_s;
      logic signed [15:0] wz_mrad_s;
   } req_type;

   typedef struct packed {
      logic               moving;
      logic [15:0]        period_ms;
      logic signed [23:0] left_wheel_mrad_s;
      logic signed [23:0] right_wheel_mrad_s;
      logic               wheel_saturated;
   } rsp_type;

   // Classified item handed from front to back.
   typedef struct packed {
      logic [31:0]        speed_sq;
      logic [15:0]        abs_wz;
      logic signed [37:0] left_num;
      logic signed [37:0] right_num;
   } work_type;

   typedef struct packed {
      logic [19:0] wheel_radius_um;
      logic [21:0] stride_um;
      logic [15:0] base_period_ms;
      logic [15:0] min_period_ms;
      logic [15:0] max_period_ms;
      logic [14:0] speed_threshold_mm_s;
      logic [14:0] yaw_threshold_mrad_s;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
   localparam logic [2:0] REG_HALF_TRACK   = 3'd1;
   localparam logic [2:0] REG_STRIDE       = 3'd2;
   localparam logic [2:0] REG_BASE_PERIOD  = 3'd3;
   localparam logic [2:0] REG_MIN_PERIOD   = 3'd4;
   localparam logic [2:0] REG_MAX_PERIOD   = 3'd5;
   localparam logic [2:0] REG_SPEED_THRESH = 3'd6;
   localparam logic [2:0] REG_YAW_THRESH   = 3'd7;

   localparam logic [19:0] RST_WHEEL_RADIUS = 20'd25000;
   localparam logic [19:0] RST_HALF_TRACK   = 20'd150000;
   localparam logic [21:0] RST_STRIDE       = 22'd157080;
   localparam logic [15:0] RST_BASE_PERIOD  = 16'd1000;
   localparam logic [15:0] RST_MIN_PERIOD   = 16'd350;
   localparam logic [15:0] RST_MAX_PERIOD   = 16'd3000;
   localparam logic [14:0] RST_SPEED_THRESH = 15'd10;
   localparam logic [14:0] RST_YAW_THRESH   = 15'd50;

   localparam logic signed [37:0] LIN_SCALE = 38'sd1000000;

   // Iteration schedule of the back end.
   localparam logic [5:0] SQRT_STEPS  = 6'd16;
   localparam logic [5:0] WHEEL_STEPS = 6'd37;
   localparam logic [5:0] LAST_STEP   = 6'd37;

   localparam logic [36:0] POS_LIMIT = 37'd8388607;
   localparam logic [36:0] NEG_LIMIT = 37'd8388608;

endpackage

`default_nettype wire

// ===== rtl/ddgp_fifo.sv =====
// ----------------------------------------------------------------------------
// ddgp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module ddgp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full    = (cnt_ff == CNT_FULL);
   assign empty   = (cnt_ff == '0);
   assign rd_data = slot_ff[rptr_ff];
   assign do_wr   = wr && !full;
   assign do_rd   = rd && !empty;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ddgp_front.sv =====
// ----------------------------------------------------------------------------
// ddgp_front
// Two-stage intake: products, then sums and wheel numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module ddgp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire ddgp_pkg::req_type req_data,
   input  wire logic [19:0]      half_track_um,
   output logic                  work_wr,
   output ddgp_pkg::work_type    work_data,
   input  wire logic             work_full
);
   import ddgp_pkg::*;

   logic               s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic               s1_adv, s2_adv;
   logic signed [31:0] vxsq_ff, vysq_ff;
   logic signed [37:0] lin_ff, rot_ff;
   logic [15:0]        awz_ff;
   work_type           work_ff;
   logic signed [31:0] vxsq, vysq;
   logic signed [37:0] lin, rot;
   logic signed [15:0] neg_wz;

   assign s2_adv    = !s2_v_ff || !work_full;
   assign s1_adv    = !s1_v_ff || s2_adv;
   assign full      = !s1_adv;
   assign work_wr   = s2_v_ff;
   assign work_data = work_ff;

   assign vxsq   = 32'(req_data.vx_mm_s) * 32'(req_data.vx_mm_s);
   assign vysq   = 32'(req_data.vy_mm_s) * 32'(req_data.vy_mm_s);
   assign lin    = 38'(req_data.vx_mm_s) * LIN_SCALE;
   assign rot    = 38'(req_data.wz_mrad_s) * signed'({18'd0, half_track_um});
   assign neg_wz = -req_data.wz_mrad_s;

   always_comb begin
      s1_v_in = s1_adv ? (push && !full) : s1_v_ff;
      s2_v_in = s2_adv ? s1_v_ff : s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         vxsq_ff <= vxsq;
         vysq_ff <= vysq;
         lin_ff  <= lin;
         rot_ff  <= rot;
         awz_ff  <= req_data.wz_mrad_s[15] ? neg_wz : req_data.wz_mrad_s;
      end
      if (s2_adv) begin
         work_ff.speed_sq  <= 32'(vxsq_ff) + 32'(vysq_ff);
         work_ff.abs_wz    <= awz_ff;
         work_ff.left_num  <= lin_ff - rot_ff;
         work_ff.right_num <= lin_ff + rot_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ddgp_back.sv =====
// ----------------------------------------------------------------------------
// ddgp_back
// Iterative engine: root, period quotient and two wheel quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module ddgp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ddgp_pkg::cfg_type cfg,
   input  wire logic              work_empty,
   output logic                   work_rd,
   input  wire ddgp_pkg::work_type work_data,
   output logic                   rsp_wr,
   output ddgp_pkg::rsp_type      rsp_data,
   input  wire logic              rsp_full
);
   import ddgp_pkg::*;

   state_type    state_ff, state_in;
   logic [5:0]   cnt_ff;
   logic [31:0]  sq_ff;
   logic [18:0]  srem_ff;
   logic [15:0]  root_ff;
   logic [21:0]  pq_ff;
   logic [15:0]  prem_ff;
   logic [36:0]  ldq_ff, rdq_ff;
   logic [19:0]  lrem_ff, rrem_ff;
   logic         lneg_ff, rneg_ff;
   logic [15:0]  awz_ff;

   logic [18:0]  s_sh, s_trial;
   logic [16:0]  p_sh;
   logic [20:0]  l_sh, r_sh;
   logic         fast;
   logic [15:0]  period;
   logic [23:0]  lval, rval;
   logic         lsat, rsat, tiny;

   assign s_sh    = {srem_ff[16:0], sq_ff[31:30]};
   assign s_trial = {1'b0, root_ff, 2'b01};
   assign p_sh    = {prem_ff, pq_ff[21]};
   assign l_sh    = {lrem_ff, ldq_ff[36]};
   assign r_sh    = {rrem_ff, rdq_ff[36]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!work_empty) state_in = ST_RUN;
         ST_RUN:  if (cnt_ff == LAST_STEP) state_in = ST_FIN;
         ST_FIN:  if (!rsp_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      work_rd = 1'b0;
      rsp_wr  = 1'b0;
      unique case (state_ff)
         ST_IDLE: work_rd = !work_empty;
         ST_RUN:  ;
         ST_FIN:  rsp_wr = !rsp_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_rd) begin
         cnt_ff  <= '0;
         sq_ff   <= work_data.speed_sq;
         srem_ff <= '0;
         root_ff <= '0;
         pq_ff   <= cfg.stride_um;
         prem_ff <= '0;
         awz_ff  <= work_data.abs_wz;
         lneg_ff <= work_data.left_num[37];
         rneg_ff <= work_data.right_num[37];
         ldq_ff  <= work_data.left_num[37] ? 37'(-work_data.left_num)
                                           : work_data.left_num[36:0];
         rdq_ff  <= work_data.right_num[37] ? 37'(-work_data.right_num)
                                            : work_data.right_num[36:0];
         lrem_ff <= '0;
         rrem_ff <= '0;
      end else if (state_ff == ST_RUN) begin
         cnt_ff <= cnt_ff + 1'b1;
         // one root digit per cycle
         if (cnt_ff < SQRT_STEPS) begin
            sq_ff <= {sq_ff[29:0], 2'b00};
            if (s_sh >= s_trial) begin
               srem_ff <= s_sh - s_trial;
               root_ff <= {root_ff[14:0], 1'b1};
            end else begin
               srem_ff <= s_sh;
               root_ff <= {root_ff[14:0], 1'b0};
            end
         end else begin
            // period quotient once the root has settled
            if (p_sh >= {1'b0, root_ff}) begin
               prem_ff <= 16'(p_sh - {1'b0, root_ff});
               pq_ff   <= {pq_ff[20:0], 1'b1};
            end else begin
               prem_ff <= p_sh[15:0];
               pq_ff   <= {pq_ff[20:0], 1'b0};
            end
         end
         if (cnt_ff < WHEEL_STEPS) begin
            if (l_sh >= {1'b0, cfg.wheel_radius_um}) begin
               lrem_ff <= 20'(l_sh - {1'b0, cfg.wheel_radius_um});
               ldq_ff  <= {ldq_ff[35:0], 1'b1};
            end else begin
               lrem_ff <= l_sh[19:0];
               ldq_ff  <= {ldq_ff[35:0], 1'b0};
            end
            if (r_sh >= {1'b0, cfg.wheel_radius_um}) begin
               rrem_ff <= 20'(r_sh - {1'b0, cfg.wheel_radius_um});
               rdq_ff  <= {rdq_ff[35:0], 1'b1};
            end else begin
               rrem_ff <= r_sh[19:0];
               rdq_ff  <= {rdq_ff[35:0], 1'b0};
            end
         end
      end
   end

   // result formatting
   always_comb begin
      fast = root_ff > {1'b0, cfg.speed_threshold_mm_s};
      if (!fast) begin
         period = cfg.base_period_ms;
      end else if (pq_ff < {6'd0, cfg.min_period_ms}) begin
         period = cfg.min_period_ms;
      end else if (pq_ff > {6'd0, cfg.max_period_ms}) begin
         period = cfg.max_period_ms;
      end else begin
         period = pq_ff[15:0];
      end

      tiny = cfg.wheel_radius_um < 20'd2;
      if (lneg_ff) begin
         lsat = ldq_ff > NEG_LIMIT;
         lval = lsat ? 24'h800000 : 24'(-ldq_ff);
      end else begin
         lsat = ldq_ff > POS_LIMIT;
         lval = lsat ? 24'h7FFFFF : ldq_ff[23:0];
      end
      if (rneg_ff) begin
         rsat = rdq_ff > NEG_LIMIT;
         rval = rsat ? 24'h800000 : 24'(-rdq_ff);
      end else begin
         rsat = rdq_ff > POS_LIMIT;
         rval = rsat ? 24'h7FFFFF : rdq_ff[23:0];
      end

      rsp_data.moving             = fast || (awz_ff > {1'b0, cfg.yaw_threshold_mrad_s});
      rsp_data.period_ms          = period;
      rsp_data.left_wheel_mrad_s  = tiny ? '0 : signed'(lval);
      rsp_data.right_wheel_mrad_s = tiny ? '0 : signed'(rval);
      rsp_data.wheel_saturated    = !tiny && (lsat || rsat);
   end

endmodule

`default_nettype wire

// ===== rtl/diff_drive_gait_planner.sv =====
// ----------------------------------------------------------------------------
// diff_drive_gait_planner
// Velocity command to gait period, moving flag and wheel rates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_data and raise push; a transaction completes at
//   a clock edge with push high and full low.
//   Result channel: while empty is low the oldest result sits on rsp_data;
//   raise pop to take it. One result per input transaction, in order.
//   Registers: csr_we with csr_index/csr_wdata writes one register at the
//   edge; change them only while the block is idle.
// Flow:
//   Front pipeline registers products, then sums; the back engine handles
//   one item at a time (load, iteration steps, an output step that waits on
//   the result queue) and sets the rate: the root comes first, then the
//   period division; the wheel divisions run beside them.
// Reset: queues empty, registers back to their default values.
// Stall: a stalled result channel fills the output queue, then holds the
//   engine, then the work queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "diff_drive_gait_planner_assert.svh"

module diff_drive_gait_planner #(
   parameter int WORK_DEPTH = 2,
   parameter int RSP_DEPTH  = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire ddgp_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output ddgp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [21:0]       csr_wdata
);
   import ddgp_pkg::*;

   cfg_type     cfg_ff;
   logic [19:0] half_track_ff;

   logic        work_wr, work_full, work_rd, work_empty;
   work_type    work_in_data, work_out_data;
   logic        rsp_wr, rsp_full;
   rsp_type     rsp_wr_data;

   // hold register file; writes are registered
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_radius_um      <= RST_WHEEL_RADIUS;
         half_track_ff               <= RST_HALF_TRACK;
         cfg_ff.stride_um            <= RST_STRIDE;
         cfg_ff.base_period_ms       <= RST_BASE_PERIOD;
         cfg_ff.min_period_ms        <= RST_MIN_PERIOD;
         cfg_ff.max_period_ms        <= RST_MAX_PERIOD;
         cfg_ff.speed_threshold_mm_s <= RST_SPEED_THRESH;
         cfg_ff.yaw_threshold_mrad_s <= RST_YAW_THRESH;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WHEEL_RADIUS: cfg_ff.wheel_radius_um      <= csr_wdata[19:0];
            REG_HALF_TRACK:   half_track_ff               <= csr_wdata[19:0];
            REG_STRIDE:       cfg_ff.stride_um            <= csr_wdata;
            REG_BASE_PERIOD:  cfg_ff.base_period_ms       <= csr_wdata[15:0];
            REG_MIN_PERIOD:   cfg_ff.min_period_ms        <= csr_wdata[15:0];
            REG_MAX_PERIOD:   cfg_ff.max_period_ms        <= csr_wdata[15:0];
            REG_SPEED_THRESH: cfg_ff.speed_threshold_mm_s <= csr_wdata[14:0];
            REG_YAW_THRESH:   cfg_ff.yaw_threshold_mrad_s <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // front: accept and classify
   ddgp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .half_track_um (half_track_ff),
      .work_wr       (work_wr),
      .work_data     (work_in_data),
      .work_full     (work_full)
   );

   // decouple front and back
   ddgp_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (WORK_DEPTH)
   ) u_work_q (
      .clock   (clock),
      .reset   (reset),
      .wr      (work_wr),
      .wr_data (work_in_data),
      .full    (work_full),
      .rd      (work_rd),
      .rd_data (work_out_data),
      .empty   (work_empty)
   );

   // back: iterate the arithmetic
   ddgp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_empty (work_empty),
      .work_rd    (work_rd),
      .work_data  (work_out_data),
      .rsp_wr     (rsp_wr),
      .rsp_data   (rsp_wr_data),
      .rsp_full   (rsp_full)
   );

   // result queue lets the engine run on while the receiver stalls, until it fills
   ddgp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr      (rsp_wr),
      .wr_data (rsp_wr_data),
      .full    (rsp_full),
      .rd      (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   `DDGP_ASSERT_IMPL(a_rsp_no_overflow, rsp_wr, !rsp_full)
   `DDGP_ASSERT_IMPL(a_work_rd_nonempty, work_rd, !work_empty)
   `DDGP_ASSERT_NEXT(a_rsp_held, !empty && !pop, !empty)

endmodule

`default_nettype wire
